// ----- src/itp_pkg.sv -----
package itp_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TOKEN     = 2'd0,
    KIND_END       = 2'd1,
    KIND_OVERFLOW  = 2'd2,
    KIND_UNMATCHED = 2'd3
  } kind_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  // source of a generated token
  typedef enum logic {
    SRC_CH,
    SRC_TOP
  } src_t;

  // character codes
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;

  // commands from controller to datapath
  typedef struct packed {
    logic  load_in;
    logic  push;
    logic  pop;
    logic  gen;
    src_t  src;
    kind_t kind;
    logic  finish;
    logic  flush;
  } itp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_end;
    logic is_space;
    logic is_digit;
    logic is_open;
    logic is_close;
    logic empty;
    logic full;
    logic top_open;
    logic top_ge;
    logic hold_valid;
    logic out_free;
  } itp_stat_t;

  // operator priority
  function automatic logic [1:0] prio(input logic [7:0] c);
    logic [1:0] p;
    case (c) inside
      CH_PLUS, CH_MINUS:            p = 2'd1;
      CH_STAR, CH_SLASH, CH_PERCENT: p = 2'd2;
      default:                      p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- src/itp_datapath.sv -----
module itp_datapath
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  itp_cmd_t   cmd,
  output itp_stat_t  stat,
  input  logic       in_action,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_token,
  output kind_t      out_kind,
  output logic       out_last
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0]    mem [STACK_DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] top_idx;
  logic [AW-1:0] raddr;
  logic [7:0]    top;
  logic          action_q;
  logic [7:0]    ch_q;
  logic          hold_valid;
  logic [7:0]    hold_token;
  kind_t         hold_kind;
  logic [7:0]    new_token;

  // held input item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_q <= in_action;
      ch_q     <= in_ch;
    end
  end

  // stack fill count
  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // stack memory, top entry read ahead into a register
  assign top_idx = count_next - CW'(1);
  assign raddr   = top_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[AW-1:0]] <= ch_q;
    end
    if (cmd.push) begin
      top <= ch_q;
    end else begin
      top <= mem[raddr];
    end
  end

  // status towards the controller
  assign stat.is_end     = action_q;
  assign stat.is_space   = (ch_q == CH_SPACE);
  assign stat.is_digit   = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign stat.is_open    = (ch_q == CH_OPEN);
  assign stat.is_close   = (ch_q == CH_CLOSE);
  assign stat.empty      = (count == '0);
  assign stat.full       = (count == CW'(STACK_DEPTH));
  assign stat.top_open   = (top == CH_OPEN);
  assign stat.top_ge     = (prio(top) >= prio(ch_q));
  assign stat.hold_valid = hold_valid;
  assign stat.out_free   = !out_valid || out_ready;

  // new result token, zero on markers
  always_comb begin
    new_token = '0;
    if (cmd.kind == KIND_TOKEN) begin
      new_token = (cmd.src == SRC_TOP) ? top : ch_q;
    end
  end

  // one-deep hold stage so the final result of an item can be marked last
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.gen && (!cmd.finish || hold_valid)) begin
      hold_valid <= 1'b1;
    end else if ((cmd.finish && !cmd.gen) || cmd.flush) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen) begin
      hold_token <= new_token;
      hold_kind  <= cmd.kind;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.gen && (hold_valid || cmd.finish)) ||
                 (cmd.finish && hold_valid) || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush || (hold_valid && (cmd.gen || cmd.finish))) begin
      out_token <= hold_token;
      out_kind  <= hold_kind;
      out_last  <= cmd.flush || !cmd.gen;
    end else if (cmd.gen && cmd.finish) begin
      out_token <= new_token;
      out_kind  <= cmd.kind;
      out_last  <= 1'b1;
    end
  end

endmodule

// ----- src/itp_ctrl.sv -----
module itp_ctrl
  import itp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  itp_stat_t stat,
  output itp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.src    = SRC_CH;
    cmd.kind   = KIND_TOKEN;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.out_free) begin
          if (stat.is_end) begin
            // drain the stack, then the end marker
            if (!stat.empty) begin
              cmd.gen = 1'b1;
              cmd.src = SRC_TOP;
              cmd.pop = 1'b1;
            end else begin
              cmd.gen    = 1'b1;
              cmd.kind   = KIND_END;
              cmd.finish = 1'b1;
            end
          end else if (stat.is_space) begin
            cmd.finish = 1'b1;
          end else if (stat.is_digit) begin
            cmd.gen    = 1'b1;
            cmd.finish = 1'b1;
          end else if (stat.is_close) begin
            // pop down to the matching open parenthesis
            if (stat.empty) begin
              cmd.gen    = 1'b1;
              cmd.kind   = KIND_UNMATCHED;
              cmd.finish = 1'b1;
            end else if (stat.top_open) begin
              cmd.pop    = 1'b1;
              cmd.finish = 1'b1;
            end else begin
              cmd.gen = 1'b1;
              cmd.src = SRC_TOP;
              cmd.pop = 1'b1;
            end
          end else if (!stat.is_open && !stat.empty && !stat.top_open &&
                       stat.top_ge) begin
            // release a stacked operator of equal or higher priority
            cmd.gen = 1'b1;
            cmd.src = SRC_TOP;
            cmd.pop = 1'b1;
          end else if (stat.full) begin
            cmd.gen    = 1'b1;
            cmd.kind   = KIND_OVERFLOW;
            cmd.finish = 1'b1;
          end else begin
            cmd.push   = 1'b1;
            cmd.finish = 1'b1;
          end
          if (cmd.finish) begin
            state_next = (cmd.gen && stat.hold_valid) ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/infix_to_postfix_converter_unit.sv -----
// channel | signals                      | accepted when
// in      | in_valid, in_ready, action, ch | in_valid && in_ready
// out     | out_valid, out_ready, token, kind, last | out_valid && out_ready
//
// an item is taken and evaluated from the next cycle: a digit, a space or a
// push ends there, and each operator popped from the stack adds a step. a
// marker that follows popped tokens adds a flush step to move the held token
// out. the stack top is read ahead from the stack memory, so one pop per cycle
// unless stalled. rst is synchronous and empties the stack; no clearing pass is
// needed. a full output register stalls evaluation until the result is taken.
module infix_to_postfix_converter_unit
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] token,
  output logic [1:0] kind,
  output logic       last
);

  itp_cmd_t  cmd;
  itp_stat_t stat;
  kind_t     kind_q;

  // sequencer
  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack, hold stage and output register
  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_action (action),
    .in_ch     (ch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_token (token),
    .out_kind  (kind_q),
    .out_last  (last)
  );

  assign kind = kind_q;

endmodule

// ----- src/itp_checker.sv -----
module itp_checker
  import itp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] token,
  input logic [1:0] kind,
  input logic       last
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // an accepted item is evaluated before the next is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is evaluated");

  // markers carry no token
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_TOKEN |-> token == 8'd0)
    else $error("marker with non-zero token");

  // markers always close an item
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_TOKEN |-> last)
    else $error("marker not flagged last");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token) && $stable(kind) &&
      $stable(last))
    else $error("stalled result changed");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (.*);

// ----- verif/tb_top.sv -----
module tb_top;
  import itp_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int ITEM_TARGET = 270;
  localparam int QUIET_FROM  = 220;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 80;

  // one expected result
  typedef struct {
    logic [7:0] token;
    kind_t      kind;
    logic       last;
  } postfix_res_t;

  // shunting yard predictor and result checker
  class postfix_scoreboard;
    logic [7:0]   stk [STACK_DEPTH];
    int           depth;
    postfix_res_t postfix_q[$];
    int           errors;
    int           n_items;
    int           n_checked;
    int           n_end;
    int           n_overflow;
    int           n_unmatched;

    function new();
      depth = 0;
      errors = 0;
      n_items = 0;
      n_checked = 0;
      n_end = 0;
      n_overflow = 0;
      n_unmatched = 0;
    endfunction

    function int op_rank(logic [7:0] c);
      if (c == CH_STAR || c == CH_SLASH || c == CH_PERCENT) return 2;
      if (c == CH_PLUS || c == CH_MINUS) return 1;
      return 0;
    endfunction

    function void emit(logic [7:0] t, kind_t k);
      postfix_res_t r;
      r.token = t;
      r.kind  = k;
      r.last  = 1'b0;
      postfix_q.push_back(r);
      if (k == KIND_END) n_end++;
      if (k == KIND_OVERFLOW) n_overflow++;
      if (k == KIND_UNMATCHED) n_unmatched++;
    endfunction

    function logic [7:0] pop_op();
      depth--;
      return stk[depth];
    endfunction

    function void push_op(logic [7:0] c);
      if (depth >= STACK_DEPTH) begin
        emit(8'd0, KIND_OVERFLOW);
      end else begin
        stk[depth] = c;
        depth++;
      end
    endfunction

    // work out the postfix results of one accepted item
    function void note_char(logic act, logic [7:0] c);
      int         first;
      bit         found;
      logic [7:0] t;
      first = postfix_q.size();
      if (act || c != CH_SPACE) n_items++;
      if (act) begin
        while (depth > 0) emit(pop_op(), KIND_TOKEN);
        emit(8'd0, KIND_END);
      end else if (c == CH_SPACE) begin
        // nothing to do
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        emit(c, KIND_TOKEN);
      end else if (c == CH_OPEN) begin
        push_op(c);
      end else if (c == CH_CLOSE) begin
        found = 1'b0;
        while (depth > 0 && !found) begin
          t = pop_op();
          if (t == CH_OPEN) found = 1'b1;
          else emit(t, KIND_TOKEN);
        end
        if (!found) emit(8'd0, KIND_UNMATCHED);
      end else begin
        // release stacked operators of equal or higher priority, stop at a bracket
        while (depth > 0 && stk[depth-1] != CH_OPEN &&
               op_rank(stk[depth-1]) >= op_rank(c))
          emit(pop_op(), KIND_TOKEN);
        push_op(c);
      end
      if (postfix_q.size() > first) postfix_q[postfix_q.size()-1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // compare one accepted result with the oldest expectation
    task check_token(logic [7:0] tok, logic [1:0] k, logic l);
      postfix_res_t e;
      if (postfix_q.size() == 0) begin
        report($sformatf("unexpected result token=%h kind=%0d last=%b", tok, k, l));
        return;
      end
      e = postfix_q.pop_front();
      n_checked++;
      if (tok !== e.token)
        report($sformatf("token %h, expected %h", tok, e.token));
      if (k !== e.kind)
        report($sformatf("kind %0d, expected %0d", k, e.kind));
      if (l !== e.last)
        report($sformatf("last %b, expected %b (token %h)", l, e.last, e.token));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       action = 1'b0;
  logic [7:0] ch = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [7:0] token;
  logic [1:0] kind;
  logic       last;

  postfix_scoreboard sb;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .ch       (ch),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .token    (token),
    .kind     (kind),
    .last     (last)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // output side: random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!out_ready) begin
      out_ready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_token(token, kind, last);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drive one item and wait for it to be taken
  task automatic send_item(input logic a, input logic [7:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= a;
    ch       <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_char(a, c);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(1'b0, c);
  endtask

  task automatic send_end();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.postfix_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 9))
      0, 1:    return CH_PLUS;
      2, 3:    return CH_MINUS;
      4, 5:    return CH_STAR;
      6:       return CH_SLASH;
      7:       return CH_PERCENT;
      8:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h3A, 8'h7E));
    endcase
  endfunction

  // well formed expression with random content, occasionally broken
  task automatic send_expr();
    int terms;
    int opens;
    terms = $urandom_range(1, 6);
    opens = 0;
    for (int k = 0; k < terms; k++) begin
      if (k > 0) send_char(pick_op());
      if ($urandom_range(0, 5) == 0) send_char(CH_SPACE);
      while (opens < 4 && $urandom_range(0, 3) == 0) begin
        send_char(CH_OPEN);
        opens++;
      end
      send_char(8'(CH_ZERO + $urandom_range(0, 9)));
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        send_char(CH_CLOSE);
        opens--;
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      while (opens > 0) begin
        send_char(CH_CLOSE);
        opens--;
      end
    end
    if ($urandom_range(0, 7) == 0) send_char(CH_CLOSE);
    send_end();
  endtask

  // deep nesting around the stack limit
  task automatic send_deep();
    int n;
    n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) send_char(pick_op());
      else send_char(CH_OPEN);
    end
    send_char(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 6)) send_char(CH_CLOSE);
    end
    send_end();
  endtask

  // random bytes and commands
  task automatic send_noise();
    repeat ($urandom_range(3, 8)) begin
      if ($urandom_range(0, 5) == 0) send_end();
      else send_char(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: mixed priorities and brackets
    send_text("(1+2)*3-4/5%6");
    send_end();
    // close bracket with nothing to match
    send_char(CH_CLOSE);
    // space, priority zero characters, byte extremes
    send_char(CH_SPACE);
    send_char("a");
    send_char(CH_ZERO);
    send_char(8'h00);
    send_char(8'hFF);
    // leftover open bracket flushed by the end command
    send_char(CH_OPEN);
    send_char(CH_PLUS);
    send_char(CH_NINE);
    send_item(1'b1, 8'hFF);
    // end command on an empty stack
    send_item(1'b1, 8'h00);

    // hold off until everything has come out
    wait_drained();

    // random part, starting with a deep nest around the stack limit
    send_deep();
    while (sb.n_items < ITEM_TARGET) begin
      if (sb.n_items >= QUIET_FROM) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0:       send_deep();
        1, 2:    send_noise();
        default: send_expr();
      endcase
    end
    send_end();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d characters and end commands, %0d results checked",
             sb.n_items, sb.n_checked);
    $display("%0d end markers, %0d stack overflows, %0d unmatched close brackets",
             sb.n_end, sb.n_overflow, sb.n_unmatched);
    if (sb.errors == 0 && sb.postfix_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/itp_pkg.sv
src/itp_datapath.sv
src/itp_ctrl.sv
src/infix_to_postfix_converter_unit.sv
src/itp_checker.sv
verif/tb_top.sv
